// ===== hw/rtl/spd_pkg.sv =====
// Shared constants, types and float helpers for the spectrum peak bin decimator.
// No dependencies; used by the stream interfaces and the top level.
`default_nettype none

package spd_pkg;

  localparam int unsigned MAX_BINS  = 65536;
  localparam int unsigned CNT_W     = 17;  // register width; holds every count and index
  localparam int unsigned IDX_W     = 16;  // reported bin index width
  localparam int unsigned DATA_W    = 32;  // IEEE single
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned DIV_CNT_W = $clog2(CNT_W);  // enough for CNT_W iterations

  localparam logic [DATA_W-1:0] NEG_INF_BITS    = 32'hFF80_0000;
  localparam logic [DATA_W-1:0] EMPTY_SPAN_BITS = 32'hC320_0000;  // -160.0

  // saturation limit; a limit beyond the register range never clamps
  localparam logic [CNT_W-1:0] MAX_BINS_C     = (MAX_BINS >= (1 << CNT_W)) ?
                                                {CNT_W{1'b1}} : CNT_W'(MAX_BINS);
  localparam logic [CNT_W-1:0] SRC_RESET_VAL  = CNT_W'(65536);
  localparam logic [CNT_W-1:0] TGT_RESET_VAL  = CNT_W'(1024);

  // register indexes (paddr bit 2 selects)
  localparam logic REG_SOURCE_COUNT = 1'b0;
  localparam logic REG_TARGET_BINS  = 1'b1;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_RUN
  } div_state_t;

  function automatic logic is_finite(input logic [DATA_W-1:0] b);
    return b[30:23] != 8'hFF;
  endfunction

  // a < b for finite singles; -0 and +0 compare equal
  function automatic logic float_lt(input logic [DATA_W-1:0] a,
                                    input logic [DATA_W-1:0] b);
    logic both_zero;
    logic res;
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (both_zero) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = a[31];
    end else if (!a[31]) begin
      res = a[30:0] < b[30:0];
    end else begin
      res = a[30:0] > b[30:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spd_stream_if.sv =====
// Valid/ready stream interfaces for the decimator's input and result channels.
// Depends on spd_pkg for field widths.
`default_nettype none

interface spd_in_if;
  logic                         valid;
  logic                         ready;
  logic [spd_pkg::DATA_W-1:0]   magnitude_bits;

  modport source (output valid, output magnitude_bits, input ready);
  modport sink   (input valid, input magnitude_bits, output ready);
endinterface

interface spd_out_if;
  logic                         valid;
  logic                         ready;
  logic [spd_pkg::DATA_W-1:0]   peak_bits;
  logic [spd_pkg::IDX_W-1:0]    bin_index;
  logic                         last_bin;

  modport source (output valid, output peak_bits, output bin_index, output last_bin,
                  input ready);
  modport sink   (input valid, input peak_bits, input bin_index, input last_bin,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spectrum_peak_bin_decimator.sv =====
// Spectrum peak bin decimator: top level with APB register port and streams.
// Depends on spd_pkg and the interfaces in spd_stream_if.sv.
//
// Usage:
//  - in_chan carries one IEEE single magnitude per transaction; out_chan carries
//    one output bin (peak value, bin index, last-of-frame flag).
//  - A frame of source_count bins is reduced to target_bins bins (clamped to
//    1..source_count); each output bin holds the largest finite value of its
//    span, or -160.0 if the span held none. Equal counts pass values through.
//  - Throughput: one input transaction per cycle. A result appears on out_chan
//    in the cycle after the input transaction that closes its span.
//  - The span step S/O is produced by a bit-serial restoring divider. It runs
//    after reset and after every register write; in_chan.ready stays low
//    while it runs. A write also drops any partial frame.
//  - Reset (rst_n low, synchronous) restores source_count 65536 and
//    target_bins 1024 and starts the divider.
//  - If out_chan is stalled, the held result stays in the output register and
//    one more input is taken only once that register is free or draining.
//  - Registers: source_count at byte 0, target_bins at byte 4; pready is
//    always high.
`default_nettype none

module spectrum_peak_bin_decimator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  spd_in_if.sink                              in_chan,
  spd_out_if.source                           out_chan,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [spd_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [spd_pkg::PDATA_W-1:0]    pwdata,
  output logic      [spd_pkg::PDATA_W-1:0]    prdata,
  output logic                                pready
);

  localparam int unsigned CW = spd_pkg::CNT_W;
  localparam int unsigned IW = spd_pkg::IDX_W;
  localparam int unsigned DW = spd_pkg::DATA_W;

  // configuration registers
  logic [CW-1:0] src_cnt_r, tgt_bins_r;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r  <= spd_pkg::SRC_RESET_VAL;
      tgt_bins_r <= spd_pkg::TGT_RESET_VAL;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        spd_pkg::REG_SOURCE_COUNT: src_cnt_r  <= pwdata[CW-1:0];
        spd_pkg::REG_TARGET_BINS:  tgt_bins_r <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      spd_pkg::REG_SOURCE_COUNT: prdata = spd_pkg::PDATA_W'(src_cnt_r);
      spd_pkg::REG_TARGET_BINS:  prdata = spd_pkg::PDATA_W'(tgt_bins_r);
      default:                   prdata = '0;
    endcase
  end

  // clamped counts
  logic [CW-1:0] s_clamp, o_clamp;
  always_comb begin
    priority if (src_cnt_r == '0)                 s_clamp = CW'(1);
    else if (src_cnt_r > spd_pkg::MAX_BINS_C)     s_clamp = spd_pkg::MAX_BINS_C;
    else                                          s_clamp = src_cnt_r;
    priority if (tgt_bins_r == '0)                o_clamp = CW'(1);
    else if (tgt_bins_r > s_clamp)                o_clamp = s_clamp;
    else                                          o_clamp = tgt_bins_r;
  end

  // divider sequencer
  spd_pkg::div_state_t div_state_r, div_state_nxt;
  logic [spd_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                          div_done;

  assign div_done = (div_state_r == spd_pkg::DIV_RUN)
                    && (div_cnt_r == spd_pkg::DIV_CNT_W'(CW - 1));

  always_comb begin
    div_state_nxt = div_state_r;
    priority if (cfg_wr) begin
      div_state_nxt = spd_pkg::DIV_LOAD;
    end else begin
      unique case (div_state_r)
        spd_pkg::DIV_IDLE: div_state_nxt = spd_pkg::DIV_IDLE;
        spd_pkg::DIV_LOAD: div_state_nxt = spd_pkg::DIV_RUN;
        spd_pkg::DIV_RUN:  div_state_nxt = div_done ? spd_pkg::DIV_IDLE : spd_pkg::DIV_RUN;
        default:           div_state_nxt = spd_pkg::DIV_LOAD;
      endcase
    end
  end

  always_comb begin
    unique case (div_state_r)
      spd_pkg::DIV_RUN: div_cnt_nxt = div_cnt_r + 1'b1;
      default:          div_cnt_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_state_r <= spd_pkg::DIV_LOAD;
      div_cnt_r   <= '0;
    end else begin
      div_state_r <= div_state_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  // restoring divide datapath, one quotient bit per cycle
  logic [CW-1:0] eff_src_r, eff_out_r;
  logic          pass_r;
  logic [CW-1:0] quo_r, rem_r;
  logic [CW:0]   rem_sh;
  logic          rem_ge;

  assign rem_sh = {rem_r, quo_r[CW-1]};
  assign rem_ge = rem_sh >= {1'b0, eff_out_r};

  always_ff @(posedge clk) begin
    unique case (div_state_r)
      spd_pkg::DIV_LOAD: begin
        eff_src_r <= s_clamp;
        eff_out_r <= o_clamp;
        pass_r    <= (s_clamp == o_clamp);
        quo_r     <= s_clamp;
        rem_r     <= '0;
      end
      spd_pkg::DIV_RUN: begin
        quo_r <= {quo_r[CW-2:0], rem_ge};
        rem_r <= rem_ge ? CW'(rem_sh - {1'b0, eff_out_r}) : rem_sh[CW-1:0];
      end
      default: ;
    endcase
  end

  // frame state; indices are kept at count width and reported modulo 2^IW
  logic [CW-1:0] src_idx_r, out_idx_r;
  logic [CW-1:0] nbe_r, brem_r;
  logic [DW-1:0] peak_r;
  logic          found_r;
  logic          busy;
  logic          out_valid_r;
  logic [DW-1:0] out_peak_r;
  logic [IW-1:0] out_idx_q_r;
  logic          out_last_r;
  logic          accept;

  assign busy          = div_state_r != spd_pkg::DIV_IDLE;
  assign in_chan.ready = !busy && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;

  // per-item compare and span bookkeeping
  logic [DW-1:0] v;
  logic          fin, upd, found_cur, span_end, last, emit;
  logic [DW-1:0] peak_cur, emit_val;
  logic [CW-1:0] src_p1, oidx_p1;
  logic [CW:0]   brem_sum;
  logic          carry;
  logic [CW-1:0] brem_new, nbe_new;
  logic [IW-1:0] emit_idx;

  always_comb begin
    v         = in_chan.magnitude_bits;
    fin       = spd_pkg::is_finite(v);
    upd       = fin && (!found_r || spd_pkg::float_lt(peak_r, v));
    peak_cur  = upd ? v : peak_r;
    found_cur = found_r || fin;
    src_p1    = src_idx_r + 1'b1;
    oidx_p1   = out_idx_r + 1'b1;
    span_end  = !(src_p1 < nbe_r);
    brem_sum  = {1'b0, brem_r} + {1'b0, rem_r};
    carry     = brem_sum >= {1'b0, eff_out_r};
    brem_new  = carry ? CW'(brem_sum - {1'b0, eff_out_r}) : brem_sum[CW-1:0];
    nbe_new   = nbe_r + quo_r + CW'(carry);
    if (pass_r) begin
      emit     = 1'b1;
      last     = src_p1 >= eff_src_r;
      emit_val = v;
      emit_idx = src_idx_r[IW-1:0];
    end else begin
      emit     = span_end;
      last     = oidx_p1 >= eff_out_r;
      emit_val = found_cur ? peak_cur : spd_pkg::EMPTY_SPAN_BITS;
      emit_idx = out_idx_r[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_idx_r <= '0;
      out_idx_r <= '0;
      found_r   <= 1'b0;
      peak_r    <= spd_pkg::NEG_INF_BITS;
      nbe_r     <= '0;
      brem_r    <= '0;
    end else if (cfg_wr || busy) begin
      // frame restart; span step loaded once the divide finishes
      src_idx_r <= '0;
      out_idx_r <= '0;
      found_r   <= 1'b0;
      peak_r    <= spd_pkg::NEG_INF_BITS;
      if (div_done) begin
        nbe_r  <= {quo_r[CW-2:0], rem_ge};
        brem_r <= rem_ge ? CW'(rem_sh - {1'b0, eff_out_r}) : rem_sh[CW-1:0];
      end
    end else if (accept) begin
      if (emit && last) begin
        src_idx_r <= '0;
        out_idx_r <= '0;
        found_r   <= 1'b0;
        peak_r    <= spd_pkg::NEG_INF_BITS;
        nbe_r     <= quo_r;
        brem_r    <= rem_r;
      end else if (pass_r) begin
        src_idx_r <= src_p1;
      end else if (span_end) begin
        src_idx_r <= src_p1;
        out_idx_r <= oidx_p1;
        found_r   <= 1'b0;
        peak_r    <= spd_pkg::NEG_INF_BITS;
        nbe_r     <= nbe_new;
        brem_r    <= brem_new;
      end else begin
        src_idx_r <= src_p1;
        found_r   <= found_cur;
        peak_r    <= peak_cur;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= emit;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_peak_r  <= emit_val;
      out_idx_q_r <= emit_idx;
      out_last_r  <= last;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.peak_bits = out_peak_r;
  assign out_chan.bin_index = out_idx_q_r;
  assign out_chan.last_bin  = out_last_r;

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_chan.ready)
    else $error("input taken while divider busy");

  a_span_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !pass_r) |-> (src_idx_r < nbe_r))
    else $error("source index passed span end");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !pass_r) |-> (brem_r < eff_out_r))
    else $error("boundary remainder out of range");

  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit && last && !cfg_wr) |=> (src_idx_r == '0 && out_idx_r == '0))
    else $error("frame not restarted after last bin");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (div_state_r == spd_pkg::DIV_RUN) |-> (div_cnt_r < spd_pkg::DIV_CNT_W'(CW)))
    else $error("divider ran too long");

endmodule

`default_nettype wire

// ===== dv/tb_spectrum_peak_bin_decimator.sv =====
// Self-checking testbench for spectrum_peak_bin_decimator: directed table, a receiver hold-off, then random frames.
// Depends on spd_pkg, spd_stream_if.sv and the RTL top level; checks against an internal predictor.
`timescale 1ns / 100ps

module tb_spectrum_peak_bin_decimator;

  typedef struct packed {
    logic [spd_pkg::DATA_W-1:0] peak;
    logic [spd_pkg::IDX_W-1:0]  idx;
    logic                       last;
  } bin_rec_t;

  typedef struct {
    bit                         wr;
    logic [spd_pkg::CNT_W-1:0]  src;
    logic [spd_pkg::CNT_W-1:0]  tgt;
    logic [spd_pkg::DATA_W-1:0] mag;
    bit                         typed;
    logic [spd_pkg::DATA_W-1:0] peak;
    logic [spd_pkg::IDX_W-1:0]  idx;
    bit                         last;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [spd_pkg::PADDR_W-1:0] paddr;
  logic [spd_pkg::PDATA_W-1:0] pwdata;
  logic [spd_pkg::PDATA_W-1:0] prdata;
  logic pready;

  spd_in_if  in_if ();
  spd_out_if out_if ();

  spectrum_peak_bin_decimator uut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // expected output bins, oldest first
  bin_rec_t expected_bins[$];
  int unsigned mismatches = 0;

  // predictor copy of registers and frame state
  logic [spd_pkg::CNT_W-1:0] src_reg, tgt_reg;
  int unsigned n_src, n_out, q_step, r_step;
  int unsigned pos, bin, span_end, rem;
  logic [spd_pkg::DATA_W-1:0] best;
  bit have_peak;

  // sender / receiver control
  int unsigned burst_left = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int unsigned hold_cnt = 0;
  int unsigned duty = 100;
  int unsigned duty_cnt = 0;

  // monotonic key for finite singles; both zeros map to the same key
  function automatic logic [31:0] order_key(input logic [spd_pkg::DATA_W-1:0] x);
    logic [31:0] k;
    if (x[30:0] == 31'd0) k = 32'h8000_0000;
    else if (x[31]) k = ~x;
    else k = x | 32'h8000_0000;
    return k;
  endfunction

  // append one bin at the tail of the expected list
  function automatic void queue_bin(input bin_rec_t r);
    expected_bins.insert(expected_bins.size(), r);
  endfunction

  function automatic void restart_frame();
    n_src = (src_reg == 0) ? 1 :
            ((src_reg > spd_pkg::MAX_BINS) ? spd_pkg::MAX_BINS : src_reg);
    n_out = (tgt_reg == 0) ? 1 : tgt_reg;
    if (n_out > n_src) n_out = n_src;
    q_step = n_src / n_out;
    r_step = n_src % n_out;
    pos = 0;
    bin = 0;
    span_end = q_step;
    rem = r_step;
    best = spd_pkg::NEG_INF_BITS;
    have_peak = 0;
  endfunction

  // one accepted magnitude; queues the output bin it closes, if any
  function automatic void predict_bin(input logic [spd_pkg::DATA_W-1:0] m);
    bin_rec_t r;
    if (n_out == n_src) begin
      r.peak = m;
      r.idx = pos[spd_pkg::IDX_W-1:0];
      r.last = (pos + 1 >= n_src);
      queue_bin(r);
      if (r.last) restart_frame();
      else pos++;
      return;
    end
    if (m[30:23] != 8'hFF) begin
      if (!have_peak || order_key(best) < order_key(m)) best = m;
      have_peak = 1;
    end
    if (pos + 1 < span_end) begin
      pos++;
      return;
    end
    r.peak = have_peak ? best : spd_pkg::EMPTY_SPAN_BITS;
    r.idx = bin[spd_pkg::IDX_W-1:0];
    r.last = (bin + 1 >= n_out);
    queue_bin(r);
    if (r.last) begin
      restart_frame();
    end else begin
      bin++;
      pos++;
      span_end += q_step;
      rem += r_step;
      if (rem >= n_out) begin
        rem -= n_out;
        span_end++;
      end
      best = spd_pkg::NEG_INF_BITS;
      have_peak = 0;
    end
  endfunction

  function automatic logic [spd_pkg::DATA_W-1:0] rand_mag();
    logic [spd_pkg::DATA_W-1:0] m;
    logic [spd_pkg::DATA_W-1:0] specials[10] = '{32'h0000_0000, 32'h8000_0000,
      32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFC0_0001, 32'h7F7F_FFFF,
      32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001};
    case ($urandom_range(0, 9))
      0: m = $urandom;
      1: m = specials[$urandom_range(0, 9)];
      2: m = {1'($urandom), 8'hFF, 23'($urandom)};
      default: m = {1'($urandom), 8'($urandom_range(120, 135)), 23'($urandom)};
    endcase
    return m;
  endfunction

  // APB write: setup then access phase
  task automatic write_reg(input logic idx, input logic [spd_pkg::CNT_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= spd_pkg::PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == spd_pkg::REG_SOURCE_COUNT) src_reg = val;
    else tgt_reg = val;
    restart_frame();
  endtask

  // wait until the block has delivered everything, then let it settle
  task automatic drain();
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [spd_pkg::CNT_W-1:0] s,
                           input logic [spd_pkg::CNT_W-1:0] t);
    in_if.valid <= 1'b0;
    burst_left = 0;
    drain();
    write_reg(spd_pkg::REG_SOURCE_COUNT, s);
    write_reg(spd_pkg::REG_TARGET_BINS, t);
  endtask

  // one input transaction; returns the index of the bin it queued, or -1
  task automatic send_mag(input logic [spd_pkg::DATA_W-1:0] m, output int qpos);
    int unsigned gap;
    int unsigned before_cnt;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_if.valid <= 1'b1;
    in_if.magnitude_bits <= m;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    before_cnt = expected_bins.size();
    predict_bin(m);
    qpos = (expected_bins.size() > before_cnt) ? expected_bins.size() - 1 : -1;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: changing duty, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 150;
      out_if.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else begin
      if (duty_cnt == 0) begin
        case ($urandom_range(0, 2))
          0: duty <= 100;
          1: duty <= 70;
          default: duty <= 30;
        endcase
        duty_cnt <= $urandom_range(16, 80);
      end else begin
        duty_cnt <= duty_cnt - 1;
      end
      out_if.ready <= ($urandom_range(0, 99) < duty);
    end
  end

  // result checker
  always @(posedge clk) begin
    bin_rec_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected bin: peak %h idx %0d last %0b",
                   out_if.peak_bits, out_if.bin_index, out_if.last_bin);
      end else begin
        exp_r = expected_bins.pop_front();
        if (exp_r.peak !== out_if.peak_bits || exp_r.idx !== out_if.bin_index ||
            exp_r.last !== out_if.last_bin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("bin mismatch: expected peak %h idx %0d last %0b, got %h %0d %0b",
                     exp_r.peak, exp_r.idx, exp_r.last,
                     out_if.peak_bits, out_if.bin_index, out_if.last_bin);
        end
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t rows[27];
    int qpos;
    int unsigned sent;
    int unsigned n_items;
    logic [spd_pkg::CNT_W-1:0] s, t;

    rows = '{
      '{0, 0, 0, 32'h3F80_0000, 0, 0, 0, 0},
      '{0, 0, 0, 32'h7F7F_FFFF, 0, 0, 0, 0},
      // pass-through keeps non-finite values
      '{1, 3, 3, 32'h7FC0_0001, 1, 32'h7FC0_0001, 0, 0},
      '{0, 0, 0, 32'h7F80_0000, 1, 32'h7F80_0000, 1, 0},
      '{0, 0, 0, 32'h0000_0000, 1, 32'h0000_0000, 2, 1},
      // span of non-finite values only
      '{1, 3, 1, 32'h7F80_0000, 0, 0, 0, 0},
      '{0, 0, 0, 32'hFF80_0000, 0, 0, 0, 0},
      '{0, 0, 0, 32'hFFFF_FFFF, 1, spd_pkg::EMPTY_SPAN_BITS, 0, 1},
      // tie on zeros keeps the earlier one
      '{1, 4, 2, 32'h8000_0000, 0, 0, 0, 0},
      '{0, 0, 0, 32'h0000_0000, 1, 32'h8000_0000, 0, 0},
      '{0, 0, 0, 32'hFF7F_FFFF, 0, 0, 0, 0},
      '{0, 0, 0, 32'h7F7F_FFFF, 1, 32'h7F7F_FFFF, 1, 1},
      // zero registers act as one
      '{1, 0, 0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 1},
      // oversized registers saturate; frame left partial, dropped by next write
      '{1, 131071, 131071, 32'h1234_5678, 1, 32'h1234_5678, 0, 0},
      '{0, 0, 0, 32'h0000_0001, 1, 32'h0000_0001, 1, 0},
      // target above source clamps to pass-through
      '{1, 5, 100, spd_pkg::EMPTY_SPAN_BITS, 1, spd_pkg::EMPTY_SPAN_BITS, 0, 0},
      '{0, 0, 0, 32'h3F80_0000, 0, 0, 0, 0},
      '{0, 0, 0, 32'h4000_0000, 0, 0, 0, 0},
      '{0, 0, 0, 32'hBF80_0000, 0, 0, 0, 0},
      '{0, 0, 0, 32'h0080_0000, 0, 0, 0, 0},
      // uneven spans
      '{1, 7, 3, 32'h4049_0FDB, 0, 0, 0, 0},
      '{0, 0, 0, 32'hC049_0FDB, 0, 0, 0, 0},
      '{0, 0, 0, 32'h7FC0_0000, 0, 0, 0, 0},
      '{0, 0, 0, 32'h4120_0000, 0, 0, 0, 0},
      '{0, 0, 0, 32'h4120_0000, 0, 0, 0, 0},
      '{0, 0, 0, 32'hFF80_0000, 0, 0, 0, 0},
      '{0, 0, 0, 32'h3DCC_CCCD, 0, 0, 0, 0}
    };

    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.magnitude_bits = '0;
    src_reg = spd_pkg::SRC_RESET_VAL;
    tgt_reg = spd_pkg::TGT_RESET_VAL;
    restart_frame();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (rows[i]) begin
      if (rows[i].wr) configure(rows[i].src, rows[i].tgt);
      send_mag(rows[i].mag, qpos);
      if (rows[i].typed && qpos >= 0)
        expected_bins[qpos] = '{rows[i].peak, rows[i].idx, rows[i].last};
    end

    // long receiver hold-off while pass-through input keeps coming
    configure(40, 40);
    hold_req = 1'b1;
    repeat (80) send_mag(rand_mag(), qpos);

    // random frames; total stays near 1350 items with the parts above
    sent = 0;
    while (sent < 1243) begin
      case ($urandom_range(0, 19))
        0: s = $urandom_range(0, 2);
        1, 2: s = $urandom_range(41, 300);
        default: s = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: t = s;
        3: t = 0;
        4: t = s + $urandom_range(1, 50);
        default: t = (s == 0) ? 1 : $urandom_range(1, s);
      endcase
      if ($urandom_range(0, 5) == 0) begin
        in_if.valid <= 1'b0;
        burst_left = 0;
        drain();
        if ($urandom_range(0, 1)) write_reg(spd_pkg::REG_SOURCE_COUNT, s);
        else write_reg(spd_pkg::REG_TARGET_BINS, t);
      end else begin
        configure(s, t);
      end
      n_items = n_src * $urandom_range(1, 3) + $urandom_range(0, n_src / 2);
      if (n_items > 1243 - sent) n_items = 1243 - sent;
      repeat (n_items) begin
        send_mag(rand_mag(), qpos);
        sent++;
      end
    end

    in_if.valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/spd_pkg.sv
hw/rtl/spd_stream_if.sv
hw/rtl/spectrum_peak_bin_decimator.sv
dv/tb_spectrum_peak_bin_decimator.sv
